/* sv/fpcp_pkg.sv */
`default_nettype none

package fpcp_pkg;

    // Byte and CRC widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 16;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    // Register reset values
    localparam logic [BYTE_W-1:0] MARK_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] MARK_SECOND_RST = 8'h55;

    // Configuration register indexes
    localparam logic REG_MARK_FIRST  = 1'b0;
    localparam logic REG_MARK_SECOND = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    // Parser phases, one-hot
    typedef enum logic [7:0] {
        PH_SOF1 = 8'b0000_0001,
        PH_SOF2 = 8'b0000_0010,
        PH_SEQ  = 8'b0000_0100,
        PH_CMD  = 8'b0000_1000,
        PH_LEN  = 8'b0001_0000,
        PH_DATA = 8'b0010_0000,
        PH_CRCH = 8'b0100_0000,
        PH_CRCL = 8'b1000_0000
    } phase_t;

    // One result item
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] pbyte;
        logic [BYTE_W-1:0] pidx;
        logic [BYTE_W-1:0] seq;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] len;
    } result_t;

    // Fold one byte into the CRC, LSB first, eight shifts
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = acc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/fpcp_parser.sv */
`default_nettype none

module fpcp_parser
    import fpcp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_fire,
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire logic [BYTE_W-1:0] mark_first,
    input  wire logic [BYTE_W-1:0] mark_second,
    output logic                   res_valid,
    output result_t                res
);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] seq_reg, seq_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] crc_high_reg, crc_high_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [CRC_W-1:0]  crc_base;
    logic [CRC_W-1:0]  crc_fed;
    logic [BYTE_W-1:0] count_inc;

    // Shared CRC update: a new frame restarts from the initial value
    assign crc_base  = (phase_reg == PH_SEQ) ? CRC_INIT : crc_reg;
    assign crc_fed   = crc_feed(crc_base, byte_in);
    assign count_inc = count_reg + 8'd1;

    // Decode the current byte against the phase
    always_comb
    begin
        phase_next    = phase_reg;
        seq_next      = seq_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        crc_high_next = crc_high_reg;
        crc_next      = crc_reg;
        res_valid     = 1'b0;
        res.kind      = KIND_PAYLOAD;
        res.pbyte     = '0;
        res.pidx      = '0;
        res.seq       = seq_reg;
        res.cmd       = cmd_reg;
        res.len       = len_reg;
        case (phase_reg)
            PH_SOF1:
            begin
                if (byte_in == mark_first)
                    phase_next = PH_SOF2;
            end
            PH_SOF2:
            begin
                if (byte_in == mark_second)
                    phase_next = PH_SEQ;
                else if (byte_in == mark_first)
                    phase_next = PH_SOF2;
                else
                    phase_next = PH_SOF1;
            end
            PH_SEQ:
            begin
                seq_next   = byte_in;
                crc_next   = crc_fed;
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                cmd_next   = byte_in;
                crc_next   = crc_fed;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                len_next   = byte_in;
                crc_next   = crc_fed;
                count_next = '0;
                phase_next = (byte_in == '0) ? PH_CRCH : PH_DATA;
            end
            PH_DATA:
            begin
                res_valid  = 1'b1;
                res.pbyte  = byte_in;
                res.pidx   = count_reg;
                crc_next   = crc_fed;
                count_next = count_inc;
                if (count_inc >= len_reg)
                    phase_next = PH_CRCH;
            end
            PH_CRCH:
            begin
                crc_high_next = byte_in;
                phase_next    = PH_CRCL;
            end
            PH_CRCL:
            begin
                res_valid  = 1'b1;
                res.kind   = ({crc_high_reg, byte_in} == crc_reg) ? KIND_GOOD : KIND_BAD;
                phase_next = PH_SOF1;
            end
            default:
            begin
                phase_next = PH_SOF1;
            end
        endcase
    end

    // Advance frame state on each byte transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SOF1;
            seq_reg      <= '0;
            cmd_reg      <= '0;
            len_reg      <= '0;
            count_reg    <= '0;
            crc_high_reg <= '0;
            crc_reg      <= '0;
        end
        else if (byte_fire)
        begin
            phase_reg    <= phase_next;
            seq_reg      <= seq_next;
            cmd_reg      <= cmd_next;
            len_reg      <= len_next;
            count_reg    <= count_next;
            crc_high_reg <= crc_high_next;
            crc_reg      <= crc_next;
        end
    end

    // Payload positions stay below the declared length
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (count_reg < len_reg))
        else $error("payload index reached declared length");

    // A zero-length frame never enters the payload phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && phase_reg == PH_LEN && byte_in == '0) |=> (phase_reg == PH_CRCH))
        else $error("zero length frame did not skip payload");

    // Verdict always returns the hunt to the first mark
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && phase_reg == PH_CRCL) |=> (phase_reg == PH_SOF1))
        else $error("parser did not restart after verdict");

endmodule

`default_nettype wire

/* sv/fpcp_out_stage.sv */
`default_nettype none

module fpcp_out_stage
    import fpcp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         push_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    out_fire;

    assign out_fire   = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    // Hold results in the output register, spill into the skid on a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg && !out_ready)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (main_valid_reg && !out_ready)
                skid_reg <= push_data;
            else
                main_reg <= push_data;
        end
    end

    // The skid is only ever used behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds a result with output register empty");

    // The skid fills only when the output register was stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && !out_ready && push))
        else $error("skid filled without a stall");

    // A pending result is never dropped by a push into a full stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_ready) |=> (skid_valid_reg && main_valid_reg))
        else $error("stalled results lost");

endmodule

`default_nettype wire

/* sv/framed_packet_crc_parser_top.sv */
// Framed packet parser with CRC16 check. One received byte is taken per
// in_valid/in_ready transfer and the block sustains one byte per clock while
// in_ready is high: the next frame state and the 8-bit CRC16 update (init
// 0xFFFF, LSB first, right-shifting against 0x8005) are combinational, and any
// result is registered on the edge that takes the byte, in the output register
// or, while that register is stalled, in the skid. A two-entry output stage
// (output register plus skid) lets bytes keep flowing while a result waits;
// in_ready drops only when both entries are full. Payload bytes come out as
// kind 0 with their index; the second CRC byte gives kind 1 (good) or kind 2
// (mismatch) with sequence, command and length. Start marks sit at APB
// addresses 0x0 and 0x4 and should be written only while the block is idle.
`default_nettype none

module framed_packet_crc_parser_top
    import fpcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [7:0]       payload_byte,
    output logic [7:0]       payload_index,
    output logic [7:0]       frame_seq,
    output logic [7:0]       frame_cmd,
    output logic [7:0]       frame_length
);

    logic [BYTE_W-1:0] mark_first_reg;
    logic [BYTE_W-1:0] mark_second_reg;
    logic              wr_en;
    logic              byte_fire;
    logic              res_valid;
    result_t           res;
    result_t           out_data;

    // Configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_first_reg  <= MARK_FIRST_RST;
            mark_second_reg <= MARK_SECOND_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_MARK_FIRST)
                mark_first_reg <= pwdata[BYTE_W-1:0];
            else
                mark_second_reg <= pwdata[BYTE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MARK_SECOND) ? {24'd0, mark_second_reg}
                                                  : {24'd0, mark_first_reg};

    // Byte transfer
    assign byte_fire = in_valid && in_ready;

    fpcp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_fire   (byte_fire),
        .byte_in     (rx_byte),
        .mark_first  (mark_first_reg),
        .mark_second (mark_second_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    fpcp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (byte_fire && res_valid),
        .push_data  (res),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // Result fields
    assign result_kind   = out_data.kind;
    assign payload_byte  = out_data.pbyte;
    assign payload_index = out_data.pidx;
    assign frame_seq     = out_data.seq;
    assign frame_cmd     = out_data.cmd;
    assign frame_length  = out_data.len;

endmodule

`default_nettype wire
